// File: rtl/ddpcm_pkg.sv
// shared constants, types and codes of the dpcm frame decoder
`default_nettype none
package ddpcm_pkg;

   localparam int SAMPLES_PER_FRAME = 50;
   localparam int FRAME_BYTES       = 40;
   localparam int TABLE_DEPTH       = 64;

   localparam int SEED_BYTES = 4;
   localparam int SAMPLE_W   = 16;
   localparam int INDEX_W    = 6;
   localparam int BYTE_W     = 8;
   localparam int SCALE_W    = 8;
   localparam int CODE_W     = $clog2(TABLE_DEPTH);
   localparam int POS_W      = $clog2(FRAME_BYTES);
   localparam int CNT_W      = $clog2(SAMPLES_PER_FRAME + 1);
   localparam int STEP_W     = $clog2(SAMPLE_W + 1);

   // predictor clamp values for out-of-range predictions
   localparam logic signed [SAMPLE_W-1:0] PRED_SAT_HIGH = 16'sd16383;
   localparam logic signed [SAMPLE_W-1:0] PRED_SAT_LOW  = -16'sd16384;

   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_DATA = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_START,
      ST_DIV,
      ST_EMIT
   } seq_state_type;

   typedef enum logic [1:0] {
      PH_FIRST,
      PH_SECOND,
      PH_THIRD
   } phase_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage
`default_nettype wire

// File: rtl/ddpcm_if.sv
// request and response channel interfaces of the dpcm frame decoder
`default_nettype none
interface ddpcm_req_if;
   import ddpcm_pkg::*;

   logic                       valid;
   logic                       ready;
   logic                       mode;
   logic [CODE_W-1:0]          table_index;
   logic signed [SAMPLE_W-1:0] table_value;
   logic [BYTE_W-1:0]          data_byte;
   logic [SCALE_W-1:0]         frame_scale;

   modport source (
      output valid, mode, table_index, table_value, data_byte, frame_scale,
      input  ready
   );
   modport sink (
      input  valid, mode, table_index, table_value, data_byte, frame_scale,
      output ready
   );
endinterface

interface ddpcm_rsp_if;
   import ddpcm_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample;
   logic [INDEX_W-1:0]         sample_index;
   logic                       last;

   modport source (
      output valid, sample, sample_index, last,
      input  ready
   );
   modport sink (
      input  valid, sample, sample_index, last,
      output ready
   );
endinterface
`default_nettype wire

// File: rtl/ddpcm_ram.sv
// generic single write port ram with registered read
`default_nettype none
module ddpcm_ram #(
   parameter int WIDTH  = 16,
   parameter int DEPTH  = 64,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// File: rtl/ddpcm_div.sv
// bit-serial signed by unsigned floor divider, one quotient bit per cycle
`default_nettype none
module ddpcm_div (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   input  wire logic signed [ddpcm_pkg::SAMPLE_W-1:0] dividend,
   input  wire logic [ddpcm_pkg::SCALE_W-1:0]    divisor,
   output ddpcm_pkg::div_status_type             status,
   output logic signed [ddpcm_pkg::SAMPLE_W-1:0] quotient
);
   import ddpcm_pkg::*;

   logic                active_ff, active_in;
   logic                done_ff, done_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic                neg_ff, neg_in;
   logic [SCALE_W-1:0]  dvs_ff, dvs_in;
   logic [SCALE_W-1:0]  rem_ff, rem_in;
   logic [SAMPLE_W-1:0] quo_ff, quo_in;
   logic signed [SAMPLE_W-1:0] result_ff, result_in;

   logic [SCALE_W:0] partial;
   logic [SCALE_W:0] trial;
   logic             fits;

   // shift in the next dividend bit and try a subtract
   assign partial = {rem_ff, quo_ff[SAMPLE_W-1]};
   assign trial   = partial - {1'b0, dvs_ff};
   assign fits    = (partial >= {1'b0, dvs_ff});

   always_comb begin
      active_in = active_ff;
      done_in   = 1'b0;
      step_in   = step_ff;
      neg_in    = neg_ff;
      dvs_in    = dvs_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      result_in = result_ff;
      if (start) begin
         active_in = 1'b1;
         step_in   = STEP_W'(SAMPLE_W);
         neg_in    = dividend[SAMPLE_W-1];
         dvs_in    = divisor;
         rem_in    = '0;
         quo_in    = dividend[SAMPLE_W-1] ? SAMPLE_W'(-dividend) : SAMPLE_W'(dividend);
      end else if (active_ff) begin
         if (step_ff != '0) begin
            rem_in  = fits ? trial[SCALE_W-1:0] : partial[SCALE_W-1:0];
            quo_in  = {quo_ff[SAMPLE_W-2:0], fits};
            step_in = step_ff - STEP_W'(1);
         end else begin
            // round toward minus infinity for negative dividends
            if (neg_ff) begin
               result_in = (rem_ff != '0) ? $signed(~quo_ff) : $signed(~quo_ff + SAMPLE_W'(1));
            end else begin
               result_in = $signed(quo_ff);
            end
            done_in   = 1'b1;
            active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
         step_ff   <= '0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
         step_ff   <= step_in;
      end
      neg_ff    <= neg_in;
      dvs_ff    <= dvs_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      result_ff <= result_in;
   end

   assign status.busy = active_ff;
   assign status.done = done_ff;
   assign quotient    = result_ff;

endmodule
`default_nettype wire

// File: rtl/ddpcm_frame_decoder.sv
// 6-bit dpcm frame decoder: quantizer table loads and frame bytes in, samples out
//
// req_if carries one word per handshake: mode 0 writes table_value into the
// 64-entry quantizer table at table_index, mode 1 delivers the next frame byte.
// frame_scale is sampled on the first byte of every 40-byte frame.
// rsp_if carries decoded samples with their index in the frame; last marks
// the final sample caused by one request word.
// req ready is high only while the sequencer is idle.
// table load: no response. seed bytes: even bytes are held, odd bytes
// complete a sample that passes through the emit step into the output register.
// code bytes: each code goes ram read, 16-step serial divide, fixup and
// emit; a byte carrying two codes runs these steps once per code.
// the output register decouples the sides: a new word is taken while a sample
// waits; a stalled receiver holds the sequencer in its emit step until the
// register frees up, nothing is dropped.
// reset (synchronous, active high) clears frame position, predictor history,
// sample count and sets the scale to one. table contents survive reset and
// are undefined until loaded; no clearing pass is done.
`default_nettype none
module ddpcm_frame_decoder (
   input wire logic       clock,
   input wire logic       reset,
   ddpcm_req_if.sink      req_if,
   ddpcm_rsp_if.source    rsp_if
);
   import ddpcm_pkg::*;

   // sequencer and frame tracking
   seq_state_type        state_ff, state_in;
   logic [POS_W-1:0]     pos_ff, pos_in;
   phase_type            phase_ff, phase_in;
   logic [BYTE_W-1:0]    held_ff, held_in;
   logic [SCALE_W-1:0]   scale_ff, scale_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 more_ff, more_in;
   logic [CODE_W-1:0]    code_ff, code_in;
   logic [CODE_W-1:0]    code2_ff, code2_in;

   // predictor history and the sample being built
   logic signed [SAMPLE_W-1:0] prev_ff, prev_in;
   logic signed [SAMPLE_W-1:0] pprev_ff, pprev_in;
   logic signed [SAMPLE_W-1:0] sample_ff, sample_in;

   // output register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_sample_ff, rsp_sample_in;
   logic [INDEX_W-1:0]         rsp_index_ff, rsp_index_in;
   logic                       rsp_last_ff, rsp_last_in;

   logic                       req_accept;
   logic                       data_accept;
   logic                       slot_free;
   logic [BYTE_W-1:0]          in_byte;
   logic signed [SAMPLE_W-1:0] ram_rd_data;
   logic                       div_start;
   logic [SCALE_W-1:0]         div_divisor;
   div_status_type             div_status;
   logic signed [SAMPLE_W-1:0] div_quotient;
   logic signed [SAMPLE_W+1:0] pred_wide;
   logic signed [SAMPLE_W-1:0] pred_sat;

   assign req_if.ready = (state_ff == ST_IDLE);
   assign req_accept   = req_if.valid && req_if.ready;
   assign data_accept  = req_accept && (req_if.mode == MODE_DATA);
   assign in_byte      = req_if.data_byte;
   assign slot_free    = !rsp_valid_ff || rsp_if.ready;

   // quantizer table
   ddpcm_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (req_accept && (req_if.mode == MODE_LOAD)),
      .wr_addr (req_if.table_index),
      .wr_data (req_if.table_value),
      .rd_addr (code_ff),
      .rd_data (ram_rd_data)
   );

   // shared serial divider, a zero scale divides by one
   assign div_start   = (state_ff == ST_START);
   assign div_divisor = (scale_ff == '0) ? SCALE_W'(1) : scale_ff;

   ddpcm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (ram_rd_data),
      .divisor  (div_divisor),
      .status   (div_status),
      .quotient (div_quotient)
   );

   // 2*prev - prevprev, clamped oddly when out of 16-bit range
   assign pred_wide = {prev_ff[SAMPLE_W-1], prev_ff, 1'b0}
                    - {{2{pprev_ff[SAMPLE_W-1]}}, pprev_ff};

   always_comb begin
      if (pred_wide > 18'sd32767) begin
         pred_sat = PRED_SAT_HIGH;
      end else if (pred_wide < -18'sd32768) begin
         pred_sat = PRED_SAT_LOW;
      end else begin
         pred_sat = pred_wide[SAMPLE_W-1:0];
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (data_accept) begin
               if (pos_ff < POS_W'(SEED_BYTES)) begin
                  if (pos_ff[0]) begin
                     state_in = ST_EMIT;
                  end
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         ST_READ:  state_in = ST_START;
         ST_START: state_in = ST_DIV;
         ST_DIV: begin
            if (div_status.done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               state_in = more_ff ? ST_READ : ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and output register
   always_comb begin
      pos_in        = pos_ff;
      phase_in      = phase_ff;
      held_in       = held_ff;
      scale_in      = scale_ff;
      count_in      = count_ff;
      more_in       = more_ff;
      code_in       = code_ff;
      code2_in      = code2_ff;
      prev_in       = prev_ff;
      pprev_in      = pprev_ff;
      sample_in     = sample_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_sample_in = rsp_sample_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_last_in   = rsp_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (data_accept) begin
               if (pos_ff == '0) begin
                  scale_in = req_if.frame_scale;
                  count_in = '0;
               end
               pos_in  = (pos_ff == POS_W'(FRAME_BYTES - 1)) ? '0 : pos_ff + POS_W'(1);
               more_in = 1'b0;
               if (pos_ff < POS_W'(SEED_BYTES)) begin
                  // big-endian seed samples
                  phase_in = PH_FIRST;
                  if (!pos_ff[0]) begin
                     held_in = in_byte;
                  end else begin
                     sample_in = $signed({held_ff, in_byte});
                  end
               end else begin
                  // four 6-bit codes in three bytes, msb first
                  case (phase_ff)
                     PH_FIRST: begin
                        code_in  = in_byte[7:2];
                        held_in  = {6'b0, in_byte[1:0]};
                        phase_in = PH_SECOND;
                     end
                     PH_SECOND: begin
                        code_in  = {held_ff[1:0], in_byte[7:4]};
                        held_in  = {4'b0, in_byte[3:0]};
                        phase_in = PH_THIRD;
                     end
                     PH_THIRD: begin
                        code_in  = {held_ff[3:0], in_byte[7:6]};
                        code2_in = in_byte[5:0];
                        more_in  = 1'b1;
                        held_in  = '0;
                        phase_in = PH_FIRST;
                     end
                     default: phase_in = PH_FIRST;
                  endcase
               end
            end
         end
         ST_DIV: begin
            if (div_status.done) begin
               sample_in = pred_sat + div_quotient;
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               // samples past the frame's quota are consumed silently
               if (count_ff < CNT_W'(SAMPLES_PER_FRAME)) begin
                  rsp_valid_in  = 1'b1;
                  rsp_sample_in = sample_ff;
                  rsp_index_in  = INDEX_W'(count_ff);
                  rsp_last_in   = !more_ff || (count_ff == CNT_W'(SAMPLES_PER_FRAME - 1));
                  pprev_in      = prev_ff;
                  prev_in       = sample_ff;
                  count_in      = count_ff + CNT_W'(1);
               end
               if (more_ff) begin
                  more_in = 1'b0;
                  code_in = code2_ff;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= '0;
         phase_ff     <= PH_FIRST;
         held_ff      <= '0;
         scale_ff     <= SCALE_W'(1);
         count_ff     <= '0;
         more_ff      <= 1'b0;
         prev_ff      <= '0;
         pprev_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         phase_ff     <= phase_in;
         held_ff      <= held_in;
         scale_ff     <= scale_in;
         count_ff     <= count_in;
         more_ff      <= more_in;
         prev_ff      <= prev_in;
         pprev_ff     <= pprev_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      code_ff       <= code_in;
      code2_ff      <= code2_in;
      sample_ff     <= sample_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.sample       = rsp_sample_ff;
   assign rsp_if.sample_index = rsp_index_ff;
   assign rsp_if.last         = rsp_last_ff;

`ifndef ASSERT_OFF
   // divider is never restarted while a division runs
   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_status.busy)
      else $error("divider started while busy");

   // a finished division is only seen while the sequencer waits for it
   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_status.done |-> (state_ff == ST_DIV))
      else $error("division finished outside the divide step");

   // sample count never passes the frame quota
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(SAMPLES_PER_FRAME))
      else $error("sample count beyond frame size");

   // a second pending code always follows through another table read
   a_more_reads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && slot_free && more_ff) |=> (state_ff == ST_READ && !more_ff))
      else $error("second code of a byte lost");
`endif

endmodule
`default_nettype wire

// File: test/ddpcm_frame_decoder_test.sv
// self-checking testbench of the dpcm frame decoder: directed and random frames and table loads
`timescale 1ns / 1ps
module ddpcm_frame_decoder_test;
   import ddpcm_pkg::*;

   // one request word as the driver puts it on the channel
   typedef struct {
      logic                       mode;
      logic [CODE_W-1:0]          table_index;
      logic signed [SAMPLE_W-1:0] table_value;
      logic [BYTE_W-1:0]          data_byte;
      logic [SCALE_W-1:0]         frame_scale;
   } req_word_type;

   // one decoded sample as it should leave the block
   typedef struct {
      logic signed [SAMPLE_W-1:0] sample;
      logic [INDEX_W-1:0]         sample_index;
      logic                       last;
   } sample_word_type;

   localparam int RANDOM_WORDS = 800;
   localparam int IDLE_PERCENT = 17;
   // worst case is far below this: ~900 words, each with up to two codes through the divider,
   // plus receiver stalls on every sample
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 200;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ddpcm_req_if req_chan ();
   ddpcm_rsp_if rsp_chan ();

   ddpcm_frame_decoder i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_chan.sink),
      .rsp_if (rsp_chan.source)
   );

   always #5 clock = ~clock;

   // stimulus and scoreboard storage
   req_word_type    input_words[$];
   sample_word_type pending_samples[$];
   req_word_type    word_on_bus;
   int              total_words;
   int              words_accepted = 0;
   int              mismatch_count = 0;
   int              cycle_count    = 0;
   int              gen_pos        = 0;

   // a stretch of the run where neither side idles
   logic no_idle;
   assign no_idle = (words_accepted >= 350) && (words_accepted < 520);

   // ---------------------------------------------------------------
   // decoder model state, mirrors what the block keeps
   // ---------------------------------------------------------------
   logic signed [SAMPLE_W-1:0] quant_table [TABLE_DEPTH];
   int                         frame_pos   = 0;
   logic [BYTE_W-1:0]          held_bits   = '0;
   logic signed [SAMPLE_W-1:0] hist_last   = '0;
   logic signed [SAMPLE_W-1:0] hist_older  = '0;
   logic [SCALE_W-1:0]         cur_scale   = 8'd1;
   int                         frame_count = 0;

   function automatic int floor_quot(int num, int den);
      int q;
      q = num / den;
      // c division truncates toward zero, step down for negative remainders
      if (num < 0 && q * den != num)
         q = q - 1;
      return q;
   endfunction

   // queue a sample unless the frame already has all of its samples
   function automatic void record_sample(logic signed [SAMPLE_W-1:0] s);
      sample_word_type w;
      if (frame_count >= SAMPLES_PER_FRAME)
         return;
      hist_older     = hist_last;
      hist_last      = s;
      w.sample       = s;
      w.sample_index = frame_count[INDEX_W-1:0];
      w.last         = 1'b0;
      pending_samples.push_back(w);
      frame_count++;
   endfunction

   // linear prediction with the odd clamp, plus floored quantizer step
   function automatic void predict_code_sample(logic [CODE_W-1:0] code);
      int pred;
      int den;
      pred = 2 * int'(hist_last) - int'(hist_older);
      den  = (cur_scale == 0) ? 1 : int'(cur_scale);
      if (pred > 32767)
         pred = int'(PRED_SAT_HIGH);
      else if (pred < -32768)
         pred = int'(PRED_SAT_LOW);
      pred = pred + floor_quot(int'(quant_table[code]), den);
      // sum wraps to 16 bits
      record_sample(pred[SAMPLE_W-1:0]);
   endfunction

   function automatic void decode_word(req_word_type w);
      int              before_n;
      phase_type       ph;
      sample_word_type tail;
      if (w.mode == MODE_LOAD) begin
         quant_table[w.table_index] = w.table_value;
         return;
      end
      before_n = pending_samples.size();
      if (frame_pos == 0) begin
         cur_scale   = w.frame_scale;
         frame_count = 0;
      end
      if (frame_pos < SEED_BYTES) begin
         // seed samples, big-endian, high byte held first
         if (frame_pos % 2 == 0)
            held_bits = w.data_byte;
         else
            record_sample({held_bits, w.data_byte});
      end else begin
         ph = phase_type'((frame_pos - SEED_BYTES) % 3);
         case (ph)
            PH_FIRST: begin
               predict_code_sample(w.data_byte[7:2]);
               held_bits = {6'd0, w.data_byte[1:0]};
            end
            PH_SECOND: begin
               predict_code_sample({held_bits[1:0], w.data_byte[7:4]});
               held_bits = {4'd0, w.data_byte[3:0]};
            end
            default: begin
               predict_code_sample({held_bits[3:0], w.data_byte[7:6]});
               predict_code_sample(w.data_byte[5:0]);
               held_bits = '0;
            end
         endcase
      end
      frame_pos++;
      if (frame_pos >= FRAME_BYTES)
         frame_pos = 0;
      // flag the final sample caused by this word
      if (pending_samples.size() > before_n) begin
         tail      = pending_samples.pop_back();
         tail.last = 1'b1;
         pending_samples.push_back(tail);
      end
   endfunction

   // ---------------------------------------------------------------
   // stimulus building
   // ---------------------------------------------------------------
   function automatic void push_load(logic [CODE_W-1:0] idx, logic signed [SAMPLE_W-1:0] val);
      req_word_type w;
      w.mode        = MODE_LOAD;
      w.table_index = idx;
      w.table_value = val;
      // ignored fields still toggle
      w.data_byte   = BYTE_W'($urandom);
      w.frame_scale = SCALE_W'($urandom);
      input_words.push_back(w);
   endfunction

   function automatic void push_byte(logic [BYTE_W-1:0] b, logic [SCALE_W-1:0] sc);
      req_word_type w;
      w.mode        = MODE_DATA;
      w.table_index = CODE_W'($urandom);
      w.table_value = SAMPLE_W'($urandom);
      w.data_byte   = b;
      w.frame_scale = sc;
      input_words.push_back(w);
      gen_pos = (gen_pos + 1) % FRAME_BYTES;
   endfunction

   // quantizer steps: full range, small and medium ones, and the extremes
   function automatic logic signed [SAMPLE_W-1:0] pick_step();
      case ($urandom_range(3))
         0: return SAMPLE_W'($urandom);
         1: return SAMPLE_W'(int'($urandom_range(255)) - 128);
         2: return SAMPLE_W'(int'($urandom_range(8191)) - 4096);
         default: begin
            case ($urandom_range(3))
               0: return -16'sd32768;
               1: return 16'sd32767;
               2: return 16'sd0;
               default: return -16'sd1;
            endcase
         end
      endcase
   endfunction

   function automatic logic [SCALE_W-1:0] pick_frame_scale();
      case ($urandom_range(9))
         0: return 8'd1;
         1: return 8'd255;
         default: return SCALE_W'($urandom_range(255, 1));
      endcase
   endfunction

   // ---------------------------------------------------------------
   // driver: holds each word until the block takes it
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            decode_word(word_on_bus);
            words_accepted++;
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (input_words.size() != 0 &&
                (no_idle || $urandom_range(99) >= IDLE_PERCENT)) begin
               word_on_bus = input_words.pop_front();
               req_chan.valid       <= 1'b1;
               req_chan.mode        <= word_on_bus.mode;
               req_chan.table_index <= word_on_bus.table_index;
               req_chan.table_value <= word_on_bus.table_value;
               req_chan.data_byte   <= word_on_bus.data_byte;
               req_chan.frame_scale <= word_on_bus.frame_scale;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // monitor: compares each sample word with the oldest expected one
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      sample_word_type exp_w;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (pending_samples.size() == 0) begin
               $error("sample word with nothing expected: sample %0d index %0d",
                      rsp_chan.sample, rsp_chan.sample_index);
               mismatch_count++;
            end else begin
               exp_w = pending_samples.pop_front();
               if (rsp_chan.sample !== exp_w.sample) begin
                  $error("sample: expected %0d, got %0d", exp_w.sample, rsp_chan.sample);
                  mismatch_count++;
               end
               if (rsp_chan.sample_index !== exp_w.sample_index) begin
                  $error("sample_index: expected %0d, got %0d",
                         exp_w.sample_index, rsp_chan.sample_index);
                  mismatch_count++;
               end
               if (rsp_chan.last !== exp_w.last) begin
                  $error("last: expected %0d, got %0d", exp_w.last, rsp_chan.last);
                  mismatch_count++;
               end
            end
         end
         rsp_chan.ready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // stimulus and end of run
   // ---------------------------------------------------------------
   initial begin
      int random_words;
      int k;
      req_chan.valid       = 1'b0;
      req_chan.mode        = MODE_LOAD;
      req_chan.table_index = '0;
      req_chan.table_value = '0;
      req_chan.data_byte   = '0;
      req_chan.frame_scale = '0;
      rsp_chan.ready       = 1'b0;

      // fill every table entry first, table contents are undefined until loaded
      for (k = 0; k < TABLE_DEPTH; k++)
         push_load(CODE_W'(k), pick_step());

      // directed part: extreme table words, zero scale, extreme seeds,
      // all-ones and all-zeros codes, a table write in the middle of a frame
      push_load(6'd0, -16'sd32768);
      push_load(6'd63, 16'sd32767);
      push_byte(8'h7f, 8'd0);    // zero scale latched, divides by one
      push_byte(8'hff, 8'd255);
      push_byte(8'h80, 8'd0);    // seeds 32767 then -32768: prediction clamps low
      push_byte(8'h00, 8'd0);
      push_byte(8'hff, 8'd0);    // four codes of 63
      push_byte(8'hff, 8'd0);
      push_byte(8'hff, 8'd0);
      push_load(6'd63, -16'sd32768);  // takes effect on the following codes
      push_byte(8'hfc, 8'd0);
      push_byte(8'h0f, 8'd0);
      push_byte(8'hff, 8'd0);
      push_byte(8'h00, 8'd0);    // four codes of 0
      push_byte(8'h00, 8'd0);
      push_byte(8'h00, 8'd0);
      push_byte(8'ha5, 8'd0);
      push_byte(8'h5a, 8'd0);
      push_byte(8'hc3, 8'd0);

      // random part: frames of random bytes with table loads mixed in
      random_words = 0;
      while (random_words < RANDOM_WORDS) begin
         if ($urandom_range(99) < 8)
            push_load(CODE_W'($urandom), pick_step());
         else if (gen_pos == 0)
            push_byte(BYTE_W'($urandom), pick_frame_scale());
         else
            push_byte(BYTE_W'($urandom), SCALE_W'($urandom));
         random_words++;
      end
      total_words = input_words.size();

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // every word taken and every sample seen, then let any stray output show
      while (words_accepted < total_words || pending_samples.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

// File: filelist.f
rtl/ddpcm_pkg.sv
rtl/ddpcm_if.sv
rtl/ddpcm_ram.sv
rtl/ddpcm_div.sv
rtl/ddpcm_frame_decoder.sv
test/ddpcm_frame_decoder_test.sv
